/* rtl/sfq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types and codes of the searchable FIFO queue.
// ----------------------------------------------------------------------------
package sfq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [2:0] {
        OP_ENQUEUE    = 3'd0,
        OP_DEQUEUE    = 3'd1,
        OP_REVERSE    = 3'd2,
        OP_FIND       = 3'd3,
        OP_REMOVE_ALL = 3'd4,
        OP_COUNT      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    // packed so that front_value sits in the low bits
    typedef struct packed {
        status_t                   status;
        logic [4:0]                queue_length;
        logic [4:0]                match_count;
        logic [3:0]                found_index;
        logic signed [VALUE_W-1:0] front_value;
    } result_t;

endpackage
`default_nettype wire

/* rtl/searchable_fifo_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// searchable_fifo_queue
// Bounded FIFO of signed 32-bit values with enqueue, dequeue, reverse, find,
// remove-all and count, one result item per input item.
// ----------------------------------------------------------------------------
// Items are processed one at a time; each returns exactly one result item.
// Dequeue of a non-empty queue reads the front entry through the entry RAM.
// Find, count and remove-all walk the stored entries through the entry RAM,
// one read per cycle, and remove-all writes each kept entry back for
// compaction in the same cycle as a read. A result waits in the output
// register while the next item is accepted; a stalled output holds back
// only the completion of the following item.
module searchable_fifo_queue #(
    parameter int DEPTH = sfq_pkg::DEPTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] operation, [34:3] operand_value, [39:35] zero
    input  wire logic [sfq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] front_value, [35:32] found_index, [40:36] match_count,
    // [45:41] queue_length, [47:46] status
    output logic [sfq_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    import sfq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    cmd_t               cmd;
    logic               start;
    logic               idle;
    logic               done;
    logic               out_free;
    result_t            res;
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [PTR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic               m_valid_reg, m_valid_next;
    result_t            m_data_reg, m_data_next;

    assign cmd.op        = op_t'(s_axis_tdata[2:0]);
    assign cmd.value     = s_axis_tdata[VALUE_W+2:3];
    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;
    assign out_free      = !m_valid_reg || m_axis_tready;

    sfq_engine #(
        .DEPTH(DEPTH)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .cmd      (cmd),
        .idle     (idle),
        .out_free (out_free),
        .done     (done),
        .res      (res),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata)
    );

    sfq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_entries (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (done) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
`default_nettype wire

/* rtl/sfq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/sfq_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfq_engine
// Operation sequencer: pointer and occupancy state, entry walk over the RAM
// for find, count, remove-all and dequeue, in-place compaction.
// ----------------------------------------------------------------------------
module sfq_engine #(
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire sfq_pkg::cmd_t            cmd,
    output logic                          idle,
    input  wire logic                     out_free,
    output logic                          done,
    output sfq_pkg::result_t              res,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [sfq_pkg::VALUE_W-1:0]   ram_wdata,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  wire logic [sfq_pkg::VALUE_W-1:0] ram_rdata
);

    import sfq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CNT_W = (OCC_W > 5) ? OCC_W : 5;
    localparam int IDX_W = (PTR_W > 4) ? PTR_W : 4;
    localparam logic [PTR_W:0] SUM_DEPTH = (PTR_W + 1)'(DEPTH);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic rev,
                                                 input logic [PTR_W-1:0] pos);
        logic [PTR_W:0] sum;
        if (rev) begin
            sum = {1'b0, base} + SUM_DEPTH - {1'b0, pos};
        end else begin
            sum = {1'b0, base} + {1'b0, pos};
        end
        if (sum >= SUM_DEPTH) begin
            sum = sum - SUM_DEPTH;
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [4:0] to5(input logic [OCC_W-1:0] v);
        logic [CNT_W-1:0] w;
        w = CNT_W'(v);
        return w[4:0];
    endfunction

    function automatic logic [3:0] to4(input logic [PTR_W-1:0] v);
        logic [IDX_W-1:0] w;
        w = IDX_W'(v);
        return w[3:0];
    endfunction

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [PTR_W-1:0]   front_reg, front_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic               rev_reg, rev_next;
    logic [OCC_W-1:0]   len_reg, len_next;
    logic [OCC_W-1:0]   rd_pos_reg, rd_pos_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [PTR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [OCC_W-1:0]   keep_reg, keep_next;
    logic [OCC_W-1:0]   hits_reg, hits_next;
    logic               hit_reg, hit_next;
    logic [PTR_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0] data_reg, data_next;
    result_t            res_reg, res_next;

    logic               needs_scan;
    logic               scan_end;
    logic               match;
    logic [OCC_W-1:0]   occ_m1;
    logic [PTR_W-1:0]   wpos;
    logic [PTR_W-1:0]   fpos;
    logic [PTR_W-1:0]   front_adv;

    assign occ_m1    = occ_reg - OCC_W'(1);
    assign match     = (ram_rdata == val_reg);
    assign scan_end  = (rd_pos_reg == len_reg) && !rd_vld_reg;
    assign wpos      = (state_reg == S_EXEC) ? occ_reg[PTR_W-1:0] : keep_reg[PTR_W-1:0];
    assign fpos      = (op_reg == OP_REVERSE) ? occ_m1[PTR_W-1:0] : PTR_W'(1);
    assign front_adv = slot_of(front_reg, rev_reg, fpos);
    assign ram_waddr = slot_of(front_reg, rev_reg, wpos);
    assign ram_raddr = slot_of(front_reg, rev_reg, rd_pos_reg[PTR_W-1:0]);

    always_comb begin
        priority case (op_reg)
            OP_DEQUEUE:    needs_scan = (occ_reg != '0);
            OP_FIND,
            OP_REMOVE_ALL,
            OP_COUNT:      needs_scan = 1'b1;
            default:       needs_scan = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = needs_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (scan_end) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next     = op_reg;
        val_next    = val_reg;
        front_next  = front_reg;
        occ_next    = occ_reg;
        rev_next    = rev_reg;
        len_next    = len_reg;
        rd_pos_next = rd_pos_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        keep_next   = keep_reg;
        hits_next   = hits_reg;
        hit_next    = hit_reg;
        idx_next    = idx_reg;
        data_next   = data_reg;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_wdata   = ram_rdata;
        idle        = (state_reg == S_IDLE);
        done        = (state_reg == S_DONE) && out_free;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    op_next     = cmd.op;
                    val_next    = cmd.value;
                    rd_pos_next = '0;
                    keep_next   = '0;
                    hits_next   = '0;
                    hit_next    = 1'b0;
                    idx_next    = '0;
                    data_next   = '0;
                    res_next    = '0;
                end
            end
            S_EXEC: begin
                res_next.queue_length = to5(occ_reg);
                len_next              = occ_reg;
                priority case (op_reg)
                    OP_ENQUEUE: begin
                        if (occ_reg == OCC_FULL) begin
                            res_next.status = ST_FULL;
                        end else begin
                            ram_we                = 1'b1;
                            ram_wdata             = val_reg;
                            occ_next              = occ_reg + OCC_W'(1);
                            res_next.queue_length = to5(occ_reg + OCC_W'(1));
                        end
                    end
                    OP_DEQUEUE: begin
                        len_next = OCC_W'(1);
                        if (occ_reg == '0) begin
                            res_next.status = ST_EMPTY;
                        end
                    end
                    OP_REVERSE: begin
                        if (occ_reg != '0) begin
                            front_next = front_adv;
                        end
                        rev_next = !rev_reg;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (rd_pos_reg < len_reg) begin
                    rd_pos_next = rd_pos_reg + OCC_W'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = rd_pos_reg[PTR_W-1:0];
                end
                if (rd_vld_reg) begin
                    priority case (op_reg)
                        OP_DEQUEUE: data_next = ram_rdata;
                        OP_FIND: begin
                            if (match && !hit_reg) begin
                                hit_next = 1'b1;
                                idx_next = rd_idx_reg;
                            end
                        end
                        OP_COUNT: begin
                            if (match) begin
                                hits_next = hits_reg + OCC_W'(1);
                            end
                        end
                        OP_REMOVE_ALL: begin
                            if (!match) begin
                                ram_we    = 1'b1;
                                keep_next = keep_reg + OCC_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (scan_end) begin
                    priority case (op_reg)
                        OP_DEQUEUE: begin
                            front_next            = front_adv;
                            occ_next              = occ_m1;
                            res_next.front_value  = data_reg;
                            res_next.queue_length = to5(occ_m1);
                        end
                        OP_FIND: begin
                            res_next.status      = hit_reg ? ST_OK : ST_NOT_FOUND;
                            res_next.found_index = to4(idx_reg);
                        end
                        OP_COUNT: begin
                            res_next.match_count = to5(hits_reg);
                        end
                        OP_REMOVE_ALL: begin
                            occ_next              = keep_reg;
                            res_next.match_count  = to5(occ_reg - keep_reg);
                            res_next.queue_length = to5(keep_reg);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DONE: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            occ_reg    <= '0;
            rev_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            occ_reg    <= occ_next;
            rev_reg    <= rev_next;
            rd_vld_reg <= rd_vld_next;
        end
        op_reg     <= op_next;
        val_reg    <= val_next;
        len_reg    <= len_next;
        rd_pos_reg <= rd_pos_next;
        rd_idx_reg <= rd_idx_next;
        keep_reg   <= keep_next;
        hits_reg   <= hits_next;
        hit_reg    <= hit_next;
        idx_reg    <= idx_next;
        data_reg   <= data_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_FULL)
        else $error("occupancy above depth");

    a_we_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_EXEC || state_reg == S_SCAN))
        else $error("RAM write outside an operation");

    a_keep_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (keep_reg <= rd_pos_reg && rd_pos_reg <= len_reg))
        else $error("compaction write ahead of read walk");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (state_reg == S_IDLE))
        else $error("result handed off without return to idle");
`endif

endmodule
`default_nettype wire
